[src/cfpd_pkg.sv]
// Shared types, constants and the CRC-16 byte update for the frame deframer.
// Used by the parser core, the top level and the testbench; no dependencies.
package cfpd_pkg;

    localparam int HEADER_BYTES = 16;
    localparam int POS_W        = 17;
    localparam int CFG_IDX_W    = 1;
    localparam int CFG_DATA_W   = 8;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'h1021;
    localparam logic [15:0] CRC_MSB  = 16'h8000;

    // Upper bound on the position: end of the longest payload.
    localparam logic [POS_W-1:0] POS_MAX = POS_W'(HEADER_BYTES + 65535);

    localparam logic [CFG_IDX_W-1:0] REG_MAGIC_FIRST  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAGIC_SECOND = 1'd1;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_BAD_CRC   = 2'd1,
        ST_BAD_MAGIC = 2'd2
    } status_t;

    typedef struct packed {
        logic [7:0]  payload_byte;
        logic        payload_valid;
        logic        frame_done;
        status_t     status;
        logic [7:0]  version;
        logic [7:0]  msg_type;
        logic [7:0]  flag_bits;
        logic [7:0]  pad_byte;
        logic [15:0] session;
        logic [31:0] sequence_res;
        logic [15:0] payload_length;
        logic [15:0] received_crc;
    } res_t;

    // CRC-16/CCITT-FALSE, one byte, MSB first.
    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in,
                                             input logic [7:0]  data);
        logic [15:0] c;
        c = crc_in ^ {data, 8'h00};
        for (int k = 0; k < 8; k++) begin
            if ((c & CRC_MSB) != 16'h0000)
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            else
                c = {c[14:0], 1'b0};
        end
        return c;
    endfunction

endpackage

[src/cfpd_if.sv]
// Valid/ready channel interfaces: the input byte stream and the frame results.
// Does not depend on cfpd_pkg; the status width is written out as two bits.
interface cfpd_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink   (input valid, input in_byte, output ready);
endinterface

interface cfpd_frame_if;
    logic        valid;
    logic        ready;
    logic [7:0]  payload_byte;
    logic        payload_valid;
    logic        frame_done;
    logic [1:0]  status;
    logic [7:0]  version;
    logic [7:0]  msg_type;
    logic [7:0]  flag_bits;
    logic [7:0]  pad_byte;
    logic [15:0] session;
    logic [31:0] sequence_res;
    logic [15:0] payload_length;
    logic [15:0] received_crc;

    modport source (output valid, output payload_byte, output payload_valid,
                    output frame_done, output status, output version,
                    output msg_type, output flag_bits, output pad_byte,
                    output session, output sequence_res, output payload_length,
                    output received_crc, input ready);
    modport sink   (input valid, input payload_byte, input payload_valid,
                    input frame_done, input status, input version,
                    input msg_type, input flag_bits, input pad_byte,
                    input session, input sequence_res, input payload_length,
                    input received_crc, output ready);
endinterface

[src/cfpd_core.sv]
// Frame parser core: byte position tracking, header capture and running CRC.
// Depends on cfpd_pkg; result is combinational from the accepted byte and state.
module cfpd_core
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  take,
    input  logic [7:0]            in_byte,
    input  logic [7:0]            magic_first,
    input  logic [7:0]            magic_second,
    output logic                  res_valid,
    output cfpd_pkg::res_t        res
);

    logic [cfpd_pkg::POS_W-1:0] pos_reg, pos_next, pos_inc;
    logic [15:0] crc_reg, crc_next;
    logic [7:0]  held_reg, held_next;
    logic [15:0] held_crc_reg, held_crc_next;
    logic [7:0]  ver_reg, ver_next;
    logic [7:0]  type_reg, type_next;
    logic [7:0]  flags_reg, flags_next;
    logic [7:0]  pad_reg, pad_next;
    logic [15:0] sess_reg, sess_next;
    logic [31:0] seq_reg, seq_next;
    logic [15:0] len_reg, len_next;
    logic [15:0] hcrc_reg, hcrc_next;
    logic        finish;

    assign pos_inc = pos_reg + cfpd_pkg::POS_W'(1);

    always_comb
    begin
        pos_next      = pos_reg;
        crc_next      = crc_reg;
        held_next     = held_reg;
        held_crc_next = held_crc_reg;
        ver_next      = ver_reg;
        type_next     = type_reg;
        flags_next    = flags_reg;
        pad_next      = pad_reg;
        sess_next     = sess_reg;
        seq_next      = seq_reg;
        len_next      = len_reg;
        hcrc_next     = hcrc_reg;
        finish        = 1'b0;
        res           = '0;
        res_valid     = 1'b0;

        if (pos_reg == cfpd_pkg::POS_W'(0)) begin
            held_next     = in_byte;
            held_crc_next = cfpd_pkg::crc_byte(cfpd_pkg::CRC_INIT, in_byte);
            pos_next      = cfpd_pkg::POS_W'(1);
        end else if (pos_reg == cfpd_pkg::POS_W'(1)) begin
            if (held_reg == magic_first && in_byte == magic_second) begin
                crc_next = cfpd_pkg::crc_byte(held_crc_reg, in_byte);
                pos_next = cfpd_pkg::POS_W'(2);
            end else begin
                // drop the held byte, retry the new one as a first magic byte
                held_next      = in_byte;
                held_crc_next  = cfpd_pkg::crc_byte(cfpd_pkg::CRC_INIT, in_byte);
                res.frame_done = 1'b1;
                res.status     = cfpd_pkg::ST_BAD_MAGIC;
                res_valid      = 1'b1;
            end
        end else if (pos_reg < cfpd_pkg::POS_W'(cfpd_pkg::HEADER_BYTES)) begin
            if (pos_reg < cfpd_pkg::POS_W'(14))
                crc_next = cfpd_pkg::crc_byte(crc_reg, in_byte);
            case (pos_reg)
                cfpd_pkg::POS_W'(2):  ver_next   = in_byte;
                cfpd_pkg::POS_W'(3):  type_next  = in_byte;
                cfpd_pkg::POS_W'(4):  flags_next = in_byte;
                cfpd_pkg::POS_W'(5):  pad_next   = in_byte;
                cfpd_pkg::POS_W'(6):  sess_next  = {sess_reg[15:8], in_byte};
                cfpd_pkg::POS_W'(7):  sess_next  = {in_byte, sess_reg[7:0]};
                cfpd_pkg::POS_W'(8):  seq_next   = {seq_reg[31:8], in_byte};
                cfpd_pkg::POS_W'(9):  seq_next   = {seq_reg[31:16], in_byte, seq_reg[7:0]};
                cfpd_pkg::POS_W'(10): seq_next   = {seq_reg[31:24], in_byte, seq_reg[15:0]};
                cfpd_pkg::POS_W'(11): seq_next   = {in_byte, seq_reg[23:0]};
                cfpd_pkg::POS_W'(12): len_next   = {len_reg[15:8], in_byte};
                cfpd_pkg::POS_W'(13): len_next   = {in_byte, len_reg[7:0]};
                cfpd_pkg::POS_W'(14): hcrc_next  = {hcrc_reg[15:8], in_byte};
                cfpd_pkg::POS_W'(15): hcrc_next  = {in_byte, hcrc_reg[7:0]};
                default: ;
            endcase
            pos_next = pos_inc;
            if (pos_inc == cfpd_pkg::POS_W'(cfpd_pkg::HEADER_BYTES)
                    && len_next == 16'h0000)
                finish = 1'b1;
        end else begin
            crc_next          = cfpd_pkg::crc_byte(crc_reg, in_byte);
            res.payload_byte  = in_byte;
            res.payload_valid = 1'b1;
            res_valid         = 1'b1;
            pos_next          = pos_inc;
            if ((pos_inc - cfpd_pkg::POS_W'(cfpd_pkg::HEADER_BYTES))
                    >= {1'b0, len_next})
                finish = 1'b1;
        end

        if (finish) begin
            res.frame_done     = 1'b1;
            res.status         = (crc_next == hcrc_next) ? cfpd_pkg::ST_OK
                                                         : cfpd_pkg::ST_BAD_CRC;
            res.version        = ver_next;
            res.msg_type       = type_next;
            res.flag_bits      = flags_next;
            res.pad_byte       = pad_next;
            res.session        = sess_next;
            res.sequence_res   = seq_next;
            res.payload_length = len_next;
            res.received_crc   = hcrc_next;
            res_valid          = 1'b1;
            pos_next           = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            pos_reg      <= '0;
            crc_reg      <= cfpd_pkg::CRC_INIT;
            held_reg     <= '0;
            held_crc_reg <= cfpd_pkg::crc_byte(cfpd_pkg::CRC_INIT, 8'h00);
            ver_reg      <= '0;
            type_reg     <= '0;
            flags_reg    <= '0;
            pad_reg      <= '0;
            sess_reg     <= '0;
            seq_reg      <= '0;
            len_reg      <= '0;
            hcrc_reg     <= '0;
        end else if (take) begin
            pos_reg      <= pos_next;
            crc_reg      <= crc_next;
            held_reg     <= held_next;
            held_crc_reg <= held_crc_next;
            ver_reg      <= ver_next;
            type_reg     <= type_next;
            flags_reg    <= flags_next;
            pad_reg      <= pad_next;
            sess_reg     <= sess_next;
            seq_reg      <= seq_next;
            len_reg      <= len_next;
            hcrc_reg     <= hcrc_next;
        end
    end

    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= cfpd_pkg::POS_MAX)
        else $error("byte position beyond end of longest frame");

    a_drop_at_magic: assert property (@(posedge clk) disable iff (!rst_n)
        (take && res_valid && res.status == cfpd_pkg::ST_BAD_MAGIC)
            |-> (pos_reg == cfpd_pkg::POS_W'(1) && !res.payload_valid))
        else $error("magic drop reported outside the magic compare");

    a_finish_rewinds: assert property (@(posedge clk) disable iff (!rst_n)
        (take && res.frame_done && res.status != cfpd_pkg::ST_BAD_MAGIC)
            |=> pos_reg == '0)
        else $error("frame end did not return to hunting");

endmodule

[src/crc_framed_packet_deframer_unit.sv]
// Top level of the CRC framed packet deframer: config registers, parser core
// and a two-entry output buffer. Depends on cfpd_pkg, cfpd_if and cfpd_core.
//
// Usage:
//   stream carries one byte per transaction (valid/ready). result carries at
//   most one transaction per input byte: a payload byte (payload_valid), a
//   frame end with OK or bad-CRC status and the header fields (frame_done),
//   or a dropped byte when the magic pair does not match (status bad magic).
//   The last payload byte and its frame end travel in the same transaction.
//   A frame reported with bad CRC must have its forwarded payload discarded.
//   Write magic_first (index 0) and magic_second (index 1) through wr_en,
//   wr_index and wr_data while the block is idle.
// Timing:
//   One byte is accepted every cycle while the skid entry is empty. Each result
//   is registered, then shown on result from the output register.
//   When the receiver stalls, one more result is parked in the skid entry;
//   stream.ready drops while that entry is full, and rises again the cycle
//   after the receiver takes a transaction.
// Reset:
//   rst_n clears the parser to magic hunting, the CRC to 0xFFFF, the header
//   fields and magic registers to zero, and empties the output buffer.
module crc_framed_packet_deframer_unit
(
    input  logic                                clk,
    input  logic                                rst_n,
    cfpd_byte_if.sink                           stream,
    cfpd_frame_if.source                        result,
    input  logic                                wr_en,
    input  logic [cfpd_pkg::CFG_IDX_W-1:0]      wr_index,
    input  logic [cfpd_pkg::CFG_DATA_W-1:0]     wr_data
);

    logic [7:0]     magic_first_reg, magic_second_reg;
    logic           take_in, out_take;
    logic           core_valid;
    cfpd_pkg::res_t core_res;

    logic           out_valid_reg, out_valid_next;
    logic           skid_valid_reg, skid_valid_next;
    cfpd_pkg::res_t out_data_reg, out_data_next;
    cfpd_pkg::res_t skid_data_reg, skid_data_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            magic_first_reg  <= '0;
            magic_second_reg <= '0;
        end else if (wr_en) begin
            unique case (wr_index)
                cfpd_pkg::REG_MAGIC_FIRST:  magic_first_reg  <= wr_data;
                cfpd_pkg::REG_MAGIC_SECOND: magic_second_reg <= wr_data;
                default: ;
            endcase
        end
    end

    assign stream.ready = !skid_valid_reg;
    assign take_in      = stream.valid && stream.ready;
    assign out_take     = out_valid_reg && result.ready;

    cfpd_core u_core
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .take         (take_in),
        .in_byte      (stream.in_byte),
        .magic_first  (magic_first_reg),
        .magic_second (magic_second_reg),
        .res_valid    (core_valid),
        .res          (core_res)
    );

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (out_take) begin
            // advance the parked entry
            out_valid_next  = skid_valid_reg;
            out_data_next   = skid_data_reg;
            skid_valid_next = 1'b0;
        end
        if (take_in && core_valid) begin
            if (!out_valid_next) begin
                out_valid_next = 1'b1;
                out_data_next  = core_res;
            end else begin
                skid_valid_next = 1'b1;
                skid_data_next  = core_res;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign result.valid          = out_valid_reg;
    assign result.payload_byte   = out_data_reg.payload_byte;
    assign result.payload_valid  = out_data_reg.payload_valid;
    assign result.frame_done     = out_data_reg.frame_done;
    assign result.status         = out_data_reg.status;
    assign result.version        = out_data_reg.version;
    assign result.msg_type       = out_data_reg.msg_type;
    assign result.flag_bits      = out_data_reg.flag_bits;
    assign result.pad_byte       = out_data_reg.pad_byte;
    assign result.session        = out_data_reg.session;
    assign result.sequence_res   = out_data_reg.sequence_res;
    assign result.payload_length = out_data_reg.payload_length;
    assign result.received_crc   = out_data_reg.received_crc;

    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry filled while output register empty");

    a_out_has_content: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_data_reg.payload_valid || out_data_reg.frame_done))
        else $error("empty transaction presented on result");

    a_stall_parks: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !result.ready && take_in && core_valid)
            |=> (skid_valid_reg && out_valid_reg))
        else $error("result lost while receiver stalled");

endmodule

[tb/tb_crc_framed_packet_deframer_unit.sv]
// Testbench for crc_framed_packet_deframer_unit: drives a byte stream of frames,
// broken frames and noise, predicts every result and checks it field by field.
// Depends on cfpd_pkg, cfpd_if and the deframer RTL.
module tb_crc_framed_packet_deframer_unit;

    localparam int DRAIN_SLACK = 4;
    localparam int LONG_HOLD   = 200;
    localparam int MAX_REPORTS = 40;

    typedef cfpd_pkg::res_t frame_res_t;

    typedef struct packed {
        logic [7:0]  ver;
        logic [7:0]  mtype;
        logic [7:0]  flags;
        logic [7:0]  pad;
        logic [15:0] sess;
        logic [31:0] seqn;
    } hdr_fields_t;

    typedef enum int {
        SINK_FREE,
        SINK_LIGHT,
        SINK_HALF,
        SINK_SPARSE
    } sink_mode_t;

    logic                           clk;
    logic                           rst_n;
    logic                           wr_en;
    logic [cfpd_pkg::CFG_IDX_W-1:0] wr_index;
    logic [7:0]                     wr_data;

    cfpd_byte_if  stream_ch ();
    cfpd_frame_if result_ch ();

    crc_framed_packet_deframer_unit uut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .stream   (stream_ch),
        .result   (result_ch),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data)
    );

    // Deframer state as predicted
    logic [cfpd_pkg::POS_W-1:0] parse_pos = '0;
    logic [15:0]      crc_acc   = 16'hFFFF;
    logic [7:0]       held_byte = 8'h00;
    logic [7:0]       magic_a   = 8'h00;
    logic [7:0]       magic_b   = 8'h00;
    logic [7:0]       hv = '0, ht = '0, hf = '0, hp = '0;
    logic [15:0]      hs = '0, hl = '0, hc = '0;
    logic [31:0]      hq = '0;

    frame_res_t  expect_q[$];
    int unsigned bytes_sent    = 0;
    int          burst_left    = 0;
    int          hold_requests = 0;
    int          mismatches    = 0;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #400000;
        $display("FAILED: results differ");
        $finish;
    end

    function automatic logic [15:0] crc16_step(input logic [15:0] c, input logic [7:0] d);
        logic [15:0] r;
        logic        fb;
        int          i;
        r = c;
        for (i = 7; i >= 0; i--)
        begin
            fb = r[15] ^ d[i];
            r  = {r[14:0], 1'b0} ^ (fb ? 16'h1021 : 16'h0000);
        end
        return r;
    endfunction

    function automatic hdr_fields_t random_header();
        hdr_fields_t h;
        h.ver   = 8'($urandom);
        h.mtype = 8'($urandom);
        h.flags = 8'($urandom);
        h.pad   = 8'($urandom);
        h.sess  = 16'($urandom);
        h.seqn  = $urandom;
        return h;
    endfunction

    function automatic logic [15:0] random_length();
        if ($urandom_range(0, 99) < 85)
            return 16'($urandom_range(0, 24));
        return 16'($urandom_range(25, 300));
    endfunction

    // Advance the predicted parser by one accepted byte
    task automatic deframe_byte(input logic [7:0] b);
        frame_res_t r;
        logic       emit;
        logic       done;
        r    = '0;
        emit = 1'b0;
        done = 1'b0;
        if (parse_pos == 0)
        begin
            held_byte = b;
            parse_pos = 1;
        end
        else if (parse_pos == 1)
        begin
            if (held_byte == magic_a && b == magic_b)
            begin
                crc_acc   = crc16_step(crc16_step(16'hFFFF, held_byte), b);
                parse_pos = 2;
            end
            else
            begin
                // drop the held byte, re-examine this one as a first byte
                held_byte    = b;
                r.frame_done = 1'b1;
                r.status     = cfpd_pkg::ST_BAD_MAGIC;
                emit         = 1'b1;
            end
        end
        else if (parse_pos < cfpd_pkg::HEADER_BYTES)
        begin
            if (parse_pos < 14)
                crc_acc = crc16_step(crc_acc, b);
            case (parse_pos)
                2:  hv = b;
                3:  ht = b;
                4:  hf = b;
                5:  hp = b;
                6:  hs[7:0]   = b;
                7:  hs[15:8]  = b;
                8:  hq[7:0]   = b;
                9:  hq[15:8]  = b;
                10: hq[23:16] = b;
                11: hq[31:24] = b;
                12: hl[7:0]   = b;
                13: hl[15:8]  = b;
                14: hc[7:0]   = b;
                15: hc[15:8]  = b;
                default: ;
            endcase
            parse_pos = parse_pos + 1;
            done      = (parse_pos == cfpd_pkg::HEADER_BYTES) && (hl == 16'h0000);
        end
        else
        begin
            crc_acc         = crc16_step(crc_acc, b);
            r.payload_byte  = b;
            r.payload_valid = 1'b1;
            emit            = 1'b1;
            parse_pos       = parse_pos + 1;
            done            = (parse_pos - cfpd_pkg::POS_W'(cfpd_pkg::HEADER_BYTES))
                              >= {1'b0, hl};
        end
        if (done)
        begin
            r.frame_done     = 1'b1;
            r.status         = (crc_acc == hc) ? cfpd_pkg::ST_OK : cfpd_pkg::ST_BAD_CRC;
            r.version        = hv;
            r.msg_type       = ht;
            r.flag_bits      = hf;
            r.pad_byte       = hp;
            r.session        = hs;
            r.sequence_res   = hq;
            r.payload_length = hl;
            r.received_crc   = hc;
            parse_pos        = '0;
            emit             = 1'b1;
        end
        if (emit)
            expect_q.push_back(r);
    endtask

    // Offer one byte in random bursts; hold it until the transaction completes
    task automatic send_byte(input logic [7:0] b);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0)
            begin
                stream_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        stream_ch.valid   <= 1'b1;
        stream_ch.in_byte <= b;
        @(posedge clk);
        while (!stream_ch.ready)
            @(posedge clk);
        deframe_byte(b);
        bytes_sent++;
    endtask

    task automatic stream_idle();
        stream_ch.valid <= 1'b0;
        burst_left = 0;
    endtask

    task automatic wait_drained();
        while (expect_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_SLACK) @(posedge clk);
    endtask

    // Drain, then write both magic registers
    task automatic set_magic(input logic [7:0] first, input logic [7:0] second);
        stream_idle();
        wait_drained();
        wr_en    <= 1'b1;
        wr_index <= cfpd_pkg::REG_MAGIC_FIRST;
        wr_data  <= first;
        @(posedge clk);
        magic_a = first;
        wr_index <= cfpd_pkg::REG_MAGIC_SECOND;
        wr_data  <= second;
        @(posedge clk);
        magic_b = second;
        wr_en <= 1'b0;
    endtask

    // Build a frame with its CRC; optionally skip the first magic byte,
    // corrupt the CRC, or cut payload bytes off the end
    task automatic send_frame(input logic [7:0] m1, input logic [7:0] m2,
                              input hdr_fields_t h, input logic [15:0] len,
                              input bit bad_crc, input bit skip_lead,
                              input int unsigned cut);
        logic [7:0]  hb[16];
        logic [7:0]  body[$];
        logic [15:0] c;
        int          i;
        hb[0] = m1;
        hb[1] = m2;
        hb[2] = h.ver;
        hb[3] = h.mtype;
        hb[4] = h.flags;
        hb[5] = h.pad;
        {hb[7], hb[6]} = h.sess;
        {hb[11], hb[10], hb[9], hb[8]} = h.seqn;
        {hb[13], hb[12]} = len;
        c = 16'hFFFF;
        for (i = 0; i < 14; i++)
            c = crc16_step(c, hb[i]);
        for (i = 0; i < int'(len); i++)
        begin
            body.push_back(8'($urandom));
            c = crc16_step(c, body[i]);
        end
        if (bad_crc)
            c = c ^ (16'h0001 << $urandom_range(0, 15));
        {hb[15], hb[14]} = c;
        for (i = skip_lead ? 1 : 0; i < 16; i++)
            send_byte(hb[i]);
        for (i = 0; i < int'(len) - int'(cut); i++)
            send_byte(body[i]);
    endtask

    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (got !== want)
        begin
            if (mismatches < MAX_REPORTS)
                $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk)
    begin : result_check
        frame_res_t want;
        frame_res_t got;
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            got.payload_byte   = result_ch.payload_byte;
            got.payload_valid  = result_ch.payload_valid;
            got.frame_done     = result_ch.frame_done;
            got.status         = cfpd_pkg::status_t'(result_ch.status);
            got.version        = result_ch.version;
            got.msg_type       = result_ch.msg_type;
            got.flag_bits      = result_ch.flag_bits;
            got.pad_byte       = result_ch.pad_byte;
            got.session        = result_ch.session;
            got.sequence_res   = result_ch.sequence_res;
            got.payload_length = result_ch.payload_length;
            got.received_crc   = result_ch.received_crc;
            if (expect_q.size() == 0)
            begin
                if (mismatches < MAX_REPORTS)
                    $display("%0t: unexpected result, expected none, actual %0h", $time, got);
                mismatches++;
            end
            else
            begin
                want = expect_q.pop_front();
                compare_field("payload_byte", want.payload_byte, got.payload_byte);
                compare_field("payload_valid", want.payload_valid, got.payload_valid);
                compare_field("frame_done", want.frame_done, got.frame_done);
                compare_field("status", want.status, got.status);
                compare_field("version", want.version, got.version);
                compare_field("msg_type", want.msg_type, got.msg_type);
                compare_field("flag_bits", want.flag_bits, got.flag_bits);
                compare_field("pad_byte", want.pad_byte, got.pad_byte);
                compare_field("session", want.session, got.session);
                compare_field("sequence_res", want.sequence_res, got.sequence_res);
                compare_field("payload_length", want.payload_length, got.payload_length);
                compare_field("received_crc", want.received_crc, got.received_crc);
            end
        end
    end

    // Receiver: switch stall pattern now and then; a hold request forces
    // ready low for a long stretch
    initial
    begin : result_sink
        sink_mode_t mode;
        int         mode_left;
        int         hold_left;
        int         hold_seen;
        int         phase;
        mode      = SINK_FREE;
        mode_left = 0;
        hold_left = 0;
        hold_seen = 0;
        phase     = 0;
        result_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_seen != hold_requests)
            begin
                hold_seen = hold_requests;
                hold_left = LONG_HOLD;
            end
            if (mode_left == 0)
            begin
                mode      = sink_mode_t'($urandom_range(0, 3));
                mode_left = $urandom_range(16, 96);
            end
            mode_left--;
            phase++;
            if (hold_left > 0)
            begin
                hold_left--;
                result_ch.ready <= 1'b0;
            end
            else
            begin
                case (mode)
                    SINK_FREE:   result_ch.ready <= 1'b1;
                    SINK_LIGHT:  result_ch.ready <= ($urandom_range(0, 3) != 0);
                    SINK_HALF:   result_ch.ready <= 1'($urandom_range(0, 1));
                    default:     result_ch.ready <= (phase % 4 == 0);
                endcase
            end
        end
    end

    task automatic test_default_magic();
        hdr_fields_t h;
        // magic registers still at their reset value
        h = '0;
        send_frame(8'h00, 8'h00, h, 16'd0, 1'b0, 1'b0, 0);
        h = '1;
        send_frame(8'h00, 8'h00, h, 16'd1, 1'b0, 1'b0, 0);
        stream_idle();
        wait_drained();
    endtask

    task automatic test_magic_search();
        // hold a first byte, then change the magic before its partner arrives
        send_byte(8'h77);
        set_magic(8'h77, 8'h88);
        send_frame(8'h77, 8'h88, random_header(), 16'd2, 1'b0, 1'b1, 0);
        // repeated first magic byte: drop one, re-examine the next
        set_magic(8'hA5, 8'h5A);
        send_byte(8'h00);
        send_byte(8'hA5);
        send_byte(8'hA5);
        send_frame(8'hA5, 8'h5A, random_header(), 16'd3, 1'b0, 1'b0, 0);
        // identical magic bytes
        set_magic(8'h3C, 8'h3C);
        send_frame(8'h3C, 8'h3C, random_header(), 16'd1, 1'b0, 1'b0, 0);
        stream_idle();
        wait_drained();
    endtask

    task automatic test_magic_registers();
        logic [15:0] pairs[4];
        int          i;
        pairs = '{16'h00FF, 16'hFF00, 16'hFFFF, 16'h8001};
        for (i = 0; i < 4; i++)
        begin
            set_magic(pairs[i][15:8], pairs[i][7:0]);
            send_frame(magic_a, magic_b, random_header(), 16'd0, 1'b0, 1'b0, 0);
            send_frame(magic_a, magic_b, random_header(), 16'd2, 1'b0, 1'b0, 0);
        end
        stream_idle();
        wait_drained();
    endtask

    task automatic test_crc_errors();
        hdr_fields_t h;
        send_frame(magic_a, magic_b, random_header(), 16'd3, 1'b1, 1'b0, 0);
        send_frame(magic_a, magic_b, random_header(), 16'd0, 1'b1, 1'b0, 0);
        // version is not checked: any value passes
        h = random_header();
        h.ver = 8'hFF;
        send_frame(magic_a, magic_b, h, 16'd5, 1'b0, 1'b0, 0);
        stream_idle();
        wait_drained();
    endtask

    task automatic test_long_payload();
        send_frame(magic_a, magic_b, random_header(), 16'd300, 1'b0, 1'b0, 0);
        stream_idle();
        wait_drained();
    endtask

    task automatic test_output_backpressure();
        hold_requests <= hold_requests + 1;
        send_frame(magic_a, magic_b, random_header(), 16'd48, 1'b0, 1'b0, 0);
        stream_idle();
        wait_drained();
    endtask

    task automatic test_random_stream();
        int unsigned stop_at;
        int unsigned last_cfg;
        int unsigned pick;
        int unsigned len;
        stop_at  = bytes_sent + 380;
        last_cfg = bytes_sent;
        while (bytes_sent < stop_at)
        begin
            if (bytes_sent - last_cfg > 150)
            begin
                case ($urandom_range(0, 3))
                    0:       set_magic(8'h00, 8'h00);
                    1:       set_magic(8'hFF, 8'hFF);
                    default: set_magic(8'($urandom), 8'($urandom));
                endcase
                last_cfg = bytes_sent;
            end
            pick = $urandom_range(0, 99);
            if (pick < 60)
                send_frame(magic_a, magic_b, random_header(), random_length(), 1'b0, 1'b0, 0);
            else if (pick < 72)
                send_frame(magic_a, magic_b, random_header(), random_length(), 1'b1, 1'b0, 0);
            else if (pick < 80)
            begin
                // truncated payload: the next bytes are swallowed as payload
                len = $urandom_range(2, 24);
                send_frame(magic_a, magic_b, random_header(), 16'(len), 1'b0, 1'b0,
                           $urandom_range(1, len));
            end
            else if (pick < 88)
                send_frame(magic_a ^ 8'($urandom_range(1, 255)), magic_b, random_header(),
                           random_length(), 1'b0, 1'b0, 0);
            else
                repeat ($urandom_range(1, 6)) send_byte(8'($urandom));
        end
        stream_idle();
        wait_drained();
    endtask

    initial
    begin
        rst_n             <= 1'b0;
        stream_ch.valid   <= 1'b0;
        stream_ch.in_byte <= 8'h00;
        wr_en             <= 1'b0;
        wr_index          <= cfpd_pkg::REG_MAGIC_FIRST;
        wr_data           <= 8'h00;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_default_magic();
        test_magic_search();
        test_magic_registers();
        test_crc_errors();
        test_long_payload();
        test_output_backpressure();
        test_random_stream();

        repeat (8) @(posedge clk);
        if (mismatches == 0 && expect_q.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
